// ===== rtl/core/ttw_pkg.sv =====
// ttw_pkg: shared types and constants of the text terminal writer
// beat structs, action codes, sequencer states, grid defaults
// no dependencies
`default_nettype none

package ttw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0A;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } result_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_ADDR,
    ST_WRITE,
    ST_LINE,
    ST_SCROLL,
    ST_BLANK,
    ST_READ,
    ST_CAPTURE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ttw_ram.sv =====
// ttw_ram: generic single write port, single read port ram
// read data registered; no reset on the array
// no dependencies
`default_nettype none

module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ttw_agen.sv =====
// ttw_agen: registered cell address unit, row * columns + col, with range flag
// shared by character writes (cursor) and cell reads
// depends on ttw_pkg
`default_nettype none

module ttw_agen #(
  parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttw_pkg::ROWS_DEF,
  parameter int AW      = $clog2(ROWS * COLUMNS)
) (
  input  wire logic                       clk,
  input  wire logic [ttw_pkg::ROW_W-1:0]  row,
  input  wire logic [ttw_pkg::COL_W-1:0]  col,
  output logic      [AW-1:0]              addr,
  output logic                            in_range
);

  localparam int SW = ttw_pkg::ROW_W + ttw_pkg::COL_W + 1;

  logic [SW-1:0] sum;

  assign sum = SW'(row) * SW'(COLUMNS) + SW'(col);

  always_ff @(posedge clk) begin
    addr     <= sum[AW-1:0];
    in_range <= ({1'b0, row} < (ttw_pkg::ROW_W + 1)'(ROWS)) &&
                ({1'b0, col} < (ttw_pkg::COL_W + 1)'(COLUMNS));
  end

endmodule

`default_nettype wire

// ===== rtl/core/text_terminal_writer.sv =====
// text_terminal_writer: top level of the character terminal engine
// sequencer, cursor, result register; instantiates ttw_agen and ttw_ram
// depends on ttw_pkg, ttw_agen and ttw_ram
`default_nettype none

// A ROWS x COLUMNS grid of 16-bit cells (character in the low byte,
// attribute in the high byte) kept in one ram, with a cursor. Each input
// beat is one action: put a character (newline moves to column 0 of the
// next row, running off the last column wraps to the next row, leaving the
// last row scrolls the grid up and blanks the bottom row), clear the grid
// and home the cursor, or read one cell. Every action returns exactly one
// result beat carrying the read value, the cursor after the action and a
// scroll flag. The block handles one action at a time through a single ram
// port pair and one address unit. Scrolls and clears copy or blank one
// cell per cycle. The sequencer also holds in its last state while the
// previous result beat is still waiting downstream. After reset the block
// sweeps the grid, writing a space in attribute 0x0A to every cell, and
// holds item_ready low until that pass ends; cfg writes are taken at any
// time and change the attribute used by later puts, blanks and clears. A
// finished result waits in an output register, so the next beat is
// accepted while it is still pending downstream.
module text_terminal_writer #(
  parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire ttw_pkg::item_t                item,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output ttw_pkg::result_t                   result,
  input  wire logic                          cfg_we,
  input  wire logic [ttw_pkg::COLOR_W-1:0]   cfg_wdata
);

  // grid geometry
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COPIES = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(CELLS + 1);

  ttw_pkg::state_t                 state, state_next;
  ttw_pkg::item_t                  item_q;
  logic [ttw_pkg::COLOR_W-1:0]     text_color;
  logic [ttw_pkg::ROW_W-1:0]       cursor_row;
  logic [ttw_pkg::COL_W-1:0]       cursor_col;
  logic [CW-1:0]                   cnt;
  logic                            scrolled_q;
  logic [ttw_pkg::CELL_W-1:0]      value_q;

  // address unit operands and result
  logic [ttw_pkg::ROW_W-1:0]       ag_row;
  logic [ttw_pkg::COL_W-1:0]       ag_col;
  logic [AW-1:0]                   ag_addr;
  logic                            ag_in_range;

  // ram port
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [ttw_pkg::CELL_W-1:0]      ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [ttw_pkg::CELL_W-1:0]      ram_rdata;

  logic                            accept;
  logic                            load_result;
  logic                            last_cell;
  logic                            last_copy;
  logic                            last_row;
  logic                            last_col;
  logic [CW-1:0]                   src_cnt;
  logic [CW-1:0]                   dst_cnt;

  assign accept    = item_valid && item_ready;
  assign last_cell = (cnt == CW'(CELLS - 1));
  assign last_copy = (cnt == CW'(COPIES));
  assign last_row  = (cursor_row == ttw_pkg::ROW_W'(ROWS - 1));
  assign last_col  = (cursor_col == ttw_pkg::COL_W'(COLUMNS - 1));
  // scroll source runs one row ahead of the destination
  assign src_cnt   = cnt + CW'(COLUMNS);
  assign dst_cnt   = cnt - CW'(1);

  // puts address the cursor, reads address the requested cell
  always_comb begin
    if (item_q.action == ttw_pkg::ACT_PUT) begin
      ag_row = cursor_row;
      ag_col = cursor_col;
    end else begin
      ag_row = item_q.cell_row;
      ag_col = item_q.cell_col;
    end
  end

  ttw_agen #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_agen (
    .clk      (clk),
    .row      (ag_row),
    .col      (ag_col),
    .addr     (ag_addr),
    .in_range (ag_in_range)
  );

  ttw_ram #(
    .WIDTH (ttw_pkg::CELL_W),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ttw_pkg::ST_FILL: begin
        if (last_cell) state_next = ttw_pkg::ST_IDLE;
      end
      ttw_pkg::ST_IDLE: begin
        if (item_valid) state_next = ttw_pkg::ST_ADDR;
      end
      ttw_pkg::ST_ADDR: begin
        case (item_q.action)
          ttw_pkg::ACT_PUT: begin
            if (item_q.char_code == ttw_pkg::NEWLINE_CODE) state_next = ttw_pkg::ST_LINE;
            else                                            state_next = ttw_pkg::ST_WRITE;
          end
          ttw_pkg::ACT_CLEAR: state_next = ttw_pkg::ST_BLANK;
          ttw_pkg::ACT_READ:  state_next = ttw_pkg::ST_READ;
          default:            state_next = ttw_pkg::ST_DONE;
        endcase
      end
      ttw_pkg::ST_WRITE: begin
        if (last_col) state_next = ttw_pkg::ST_LINE;
        else          state_next = ttw_pkg::ST_DONE;
      end
      ttw_pkg::ST_LINE: begin
        if (last_row) state_next = ttw_pkg::ST_SCROLL;
        else          state_next = ttw_pkg::ST_DONE;
      end
      ttw_pkg::ST_SCROLL: begin
        if (last_copy) state_next = ttw_pkg::ST_BLANK;
      end
      ttw_pkg::ST_BLANK: begin
        if (last_cell) state_next = ttw_pkg::ST_DONE;
      end
      ttw_pkg::ST_READ:    state_next = ttw_pkg::ST_CAPTURE;
      ttw_pkg::ST_CAPTURE: state_next = ttw_pkg::ST_DONE;
      ttw_pkg::ST_DONE: begin
        if (!result_valid || result_ready) state_next = ttw_pkg::ST_IDLE;
      end
      default: state_next = ttw_pkg::ST_IDLE;
    endcase
  end

  // ram controls and handshake
  always_comb begin
    item_ready  = (state == ttw_pkg::ST_IDLE);
    load_result = (state == ttw_pkg::ST_DONE) && (!result_valid || result_ready);
    ram_we      = 1'b0;
    ram_waddr   = cnt[AW-1:0];
    ram_wdata   = {text_color, ttw_pkg::SPACE_CODE};
    ram_raddr   = ag_addr;
    case (state)
      ttw_pkg::ST_FILL: begin
        // power-up grid uses the reset attribute whatever cfg holds
        ram_we    = 1'b1;
        ram_wdata = {ttw_pkg::RESET_COLOR, ttw_pkg::SPACE_CODE};
      end
      ttw_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = ag_addr;
        ram_wdata = {text_color, item_q.char_code};
      end
      ttw_pkg::ST_SCROLL: begin
        // read one row down, write back the cell read last cycle
        ram_raddr = src_cnt[AW-1:0];
        ram_we    = (cnt != '0);
        ram_waddr = dst_cnt[AW-1:0];
        ram_wdata = ram_rdata;
      end
      ttw_pkg::ST_BLANK: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ttw_pkg::ST_FILL;
      text_color   <= ttw_pkg::RESET_COLOR;
      cursor_row   <= '0;
      cursor_col   <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ttw_pkg::ST_FILL: cnt <= cnt + CW'(1);
        ttw_pkg::ST_IDLE: begin
          if (accept) cnt <= '0;
        end
        ttw_pkg::ST_ADDR: begin
          if (item_q.action == ttw_pkg::ACT_CLEAR) begin
            cursor_row <= '0;
            cursor_col <= '0;
          end
        end
        ttw_pkg::ST_WRITE: cursor_col <= cursor_col + ttw_pkg::COL_W'(1);
        ttw_pkg::ST_LINE: begin
          cursor_col <= '0;
          if (last_row) cnt <= '0;
          else          cursor_row <= cursor_row + ttw_pkg::ROW_W'(1);
        end
        ttw_pkg::ST_SCROLL: begin
          if (!last_copy) cnt <= cnt + CW'(1);
        end
        ttw_pkg::ST_BLANK: cnt <= cnt + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q     <= item;
      scrolled_q <= 1'b0;
      value_q    <= '0;
    end
    if (state == ttw_pkg::ST_LINE && last_row) begin
      scrolled_q <= 1'b1;
    end
    if (state == ttw_pkg::ST_CAPTURE) begin
      value_q <= ag_in_range ? ram_rdata : '0;
    end
    if (load_result) begin
      result.cell_value <= value_q;
      result.cursor_row <= cursor_row;
      result.cursor_col <= cursor_col;
      result.scrolled   <= scrolled_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ttw_checker.sv =====
// ttw_checker: port-level assertions for text_terminal_writer, bound to it
// watches the item and result channels only
// depends on ttw_pkg
`default_nettype none

module ttw_checker #(
  parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_valid,
  input wire logic                        item_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire ttw_pkg::result_t            result
);

  // a pending result beat holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // one action at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item_ready high right after accept");

  // reported cursor stays on the grid
  a_cursor_on_grid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.cursor_row} < (ttw_pkg::ROW_W + 1)'(ROWS)) &&
                     ({1'b0, result.cursor_col} < (ttw_pkg::COL_W + 1)'(COLUMNS)))
    else $error("cursor off the grid");

  // a scroll leaves the cursor at the start of the bottom row, with no read data
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.scrolled |->
      result.cursor_row == ttw_pkg::ROW_W'(ROWS - 1) && result.cursor_col == '0 &&
      result.cell_value == '0)
    else $error("scroll result inconsistent");

endmodule

bind text_terminal_writer ttw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_ttw_checker (.*);

`default_nettype wire
